>>> rtl/eap_pkg.sv
// encoder angle processor package: register map, reset values, config and command types
// no dependencies; used by the register file, controller, datapath and top level of the block
package eap_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_COUNT_TOP   = 3'd0;
  localparam logic [2:0] REG_COUNT_SCALE = 3'd1;
  localparam logic [2:0] REG_REVERSE     = 3'd2;
  localparam logic [2:0] REG_POLE_PAIRS  = 3'd3;
  localparam logic [2:0] REG_MECH_OFFSET = 3'd4;
  localparam logic [2:0] REG_ELEC_OFFSET = 3'd5;

  localparam logic [15:0] RST_COUNT_TOP   = 16'd3999;
  localparam logic [31:0] RST_COUNT_SCALE = 32'd1074005;
  localparam logic        RST_REVERSE     = 1'b0;
  localparam logic [5:0]  RST_POLE_PAIRS  = 6'd7;
  localparam logic [15:0] RST_MECH_OFFSET = 16'd0;
  localparam logic [15:0] RST_ELEC_OFFSET = 16'd53900;

  typedef struct packed {
    logic [15:0] count_top;
    logic [31:0] count_scale;
    logic        reverse_direction;
    logic [5:0]  pole_pairs;
    logic [15:0] mech_offset;
    logic [15:0] elec_offset;
  } cfg_t;

  // one step of the datapath per flag
  typedef struct packed {
    logic capture;
    logic mul;
    logic angle;
    logic finish;
  } cmd_t;

endpackage

>>> rtl/eap_regs.sv
// encoder angle processor configuration registers behind an apb-style port
// depends on eap_pkg for the register map and reset values
module eap_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eap_pkg::ADDR_W-1:0]  paddr,
  input  logic [eap_pkg::DATA_W-1:0]  pwdata,
  output logic [eap_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output eap_pkg::cfg_t               cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_top         <= eap_pkg::RST_COUNT_TOP;
      cfg.count_scale       <= eap_pkg::RST_COUNT_SCALE;
      cfg.reverse_direction <= eap_pkg::RST_REVERSE;
      cfg.pole_pairs        <= eap_pkg::RST_POLE_PAIRS;
      cfg.mech_offset       <= eap_pkg::RST_MECH_OFFSET;
      cfg.elec_offset       <= eap_pkg::RST_ELEC_OFFSET;
    end else if (wr_en) begin
      unique case (index)
        eap_pkg::REG_COUNT_TOP:   cfg.count_top         <= pwdata[15:0];
        eap_pkg::REG_COUNT_SCALE: cfg.count_scale       <= pwdata;
        eap_pkg::REG_REVERSE:     cfg.reverse_direction <= pwdata[0];
        eap_pkg::REG_POLE_PAIRS:  cfg.pole_pairs        <= pwdata[5:0];
        eap_pkg::REG_MECH_OFFSET: cfg.mech_offset       <= pwdata[15:0];
        eap_pkg::REG_ELEC_OFFSET: cfg.elec_offset       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      eap_pkg::REG_COUNT_TOP:   prdata = {16'd0, cfg.count_top};
      eap_pkg::REG_COUNT_SCALE: prdata = cfg.count_scale;
      eap_pkg::REG_REVERSE:     prdata = {31'd0, cfg.reverse_direction};
      eap_pkg::REG_POLE_PAIRS:  prdata = {26'd0, cfg.pole_pairs};
      eap_pkg::REG_MECH_OFFSET: prdata = {16'd0, cfg.mech_offset};
      eap_pkg::REG_ELEC_OFFSET: prdata = {16'd0, cfg.elec_offset};
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> rtl/eap_ctrl.sv
// encoder angle processor controller: sequences capture, multiply, angle and finish steps
// depends on eap_pkg for the command struct; owns the input ready and output valid flags
module eap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output eap_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ANG  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.mul     = (state == ST_MUL);
  assign cmd.angle   = (state == ST_ANG);
  // result register must be empty or emptying before the finish step commits
  assign cmd.finish  = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.capture) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ANG;
      ST_ANG:  state_next = ST_FIN;
      ST_FIN:  if (cmd.finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/eap_datapath.sv
// encoder angle processor datapath: count scaling, offsets, pole multiply, revolution tracking
// depends on eap_pkg for config and command types; steps are driven by eap_ctrl
module eap_datapath #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  eap_pkg::cfg_t      cfg,
  input  eap_pkg::cmd_t      cmd,
  input  logic [15:0]        raw_count,
  output logic [15:0]        mech_angle,
  output logic [15:0]        single_turn_angle,
  output logic [15:0]        elec_angle,
  output logic signed [15:0] revolutions,
  output logic signed [31:0] multi_turn_position
);

  localparam int DW = ANGLE_BITS + 4;
  localparam logic signed [DW-1:0] LIM_POS = DW'(64'sd4 << ANGLE_BITS);
  localparam logic signed [DW-1:0] LIM_NEG = -LIM_POS;

  logic signed [16:0]           count_d;
  logic signed [16:0]           count_d_next;
  logic signed [49:0]           prod_full;
  logic [31:0]                  prod;
  logic [ANGLE_BITS-1:0]        angle;
  logic [ANGLE_BITS-1:0]        previous_angle;
  logic signed [15:0]           revolution_count;
  logic signed [15:0]           revolution_count_next;
  logic [ANGLE_BITS+5:0]        pole_prod;
  logic [ANGLE_BITS-1:0]        elec_val;
  logic [ANGLE_BITS-1:0]        single_val;
  logic signed [ANGLE_BITS:0]   diff;
  logic signed [DW-1:0]         diff_ext;
  logic signed [DW-1:0]         diff_x5;
  logic [31:0]                  multi_val;

  // mirrored count may go negative and is scaled as a signed value
  assign count_d_next = cfg.reverse_direction ?
                        ($signed({1'b0, cfg.count_top}) - $signed({1'b0, raw_count})) :
                        $signed({1'b0, raw_count});

  assign prod_full = count_d * $signed({1'b0, cfg.count_scale});

  assign pole_prod  = angle * cfg.pole_pairs;
  assign elec_val   = pole_prod[ANGLE_BITS-1:0] - ANGLE_BITS'(cfg.elec_offset);
  assign single_val = angle + ANGLE_BITS'(cfg.mech_offset);

  // jump of more than 0.8 turn: 5*diff against 4 turns
  assign diff     = $signed({1'b0, angle}) - $signed({1'b0, previous_angle});
  assign diff_ext = DW'(diff);
  assign diff_x5  = (diff_ext <<< 2) + diff_ext;

  always_comb begin
    revolution_count_next = revolution_count;
    if (diff_x5 > LIM_POS) begin
      revolution_count_next = revolution_count - 16'sd1;
    end else if (diff_x5 < LIM_NEG) begin
      revolution_count_next = revolution_count + 16'sd1;
    end
  end

  assign multi_val = (32'(revolution_count_next) << ANGLE_BITS) + 32'(angle);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_d <= count_d_next;
    end
    if (cmd.mul) begin
      prod <= prod_full[31:0];
    end
    if (cmd.angle) begin
      angle <= prod[31 -: ANGLE_BITS];
    end
    if (cmd.finish) begin
      mech_angle          <= 16'(angle);
      single_turn_angle   <= 16'(single_val);
      elec_angle          <= 16'(elec_val);
      revolutions         <= revolution_count_next;
      multi_turn_position <= multi_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_angle   <= '0;
      revolution_count <= '0;
    end else if (cmd.finish) begin
      previous_angle   <= angle;
      revolution_count <= revolution_count_next;
    end
  end

endmodule

>>> rtl/encoder_angle_processor_unit.sv
// encoder angle processor top level: apb register file, controller and datapath
// depends on eap_pkg, eap_regs, eap_ctrl and eap_datapath
//
// usage:
//   configuration registers sit on the apb-style port at byte address 4*index
//   (count_top, count_scale, reverse_direction, pole_pairs, mech_offset,
//   elec_offset); write them only while the block is idle. pready is always high.
//   the input channel takes one raw encoder count per word (in_valid/in_ready);
//   the output channel returns one word per input with the mechanical, offset
//   single-turn and electrical angles, the revolution count and the multi-turn
//   position (out_valid/out_ready).
//   the sequencer takes each count through the capture, count-scale multiply,
//   angle and finish steps; one item is in flight at a time and a new one is
//   taken only once the last has left the finish step.
//   the result sits in an output register, so the next count is accepted and
//   worked while a stalled result waits; the finish step then holds until the
//   receiver takes that result.
//   reset clears the registers to their defaults, the revolution counter and
//   the previous angle to zero, and drops out_valid.
module encoder_angle_processor_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eap_pkg::ADDR_W-1:0]  paddr,
  input  logic [eap_pkg::DATA_W-1:0]  pwdata,
  output logic [eap_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 raw_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 mech_angle,
  output logic [15:0]                 single_turn_angle,
  output logic [15:0]                 elec_angle,
  output logic signed [15:0]          revolutions,
  output logic signed [31:0]          multi_turn_position
);

  eap_pkg::cfg_t cfg;
  eap_pkg::cmd_t cmd;

  eap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  eap_datapath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .raw_count           (raw_count),
    .mech_angle          (mech_angle),
    .single_turn_angle   (single_turn_angle),
    .elec_angle          (elec_angle),
    .revolutions         (revolutions),
    .multi_turn_position (multi_turn_position)
  );

endmodule

>>> rtl/eap_checker.sv
// encoder angle processor port checker and its bind to the top level
// depends only on the top level's ports
module eap_checker #(
  parameter int ANGLE_BITS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        mech_angle,
  input logic signed [15:0] revolutions,
  input logic signed [31:0] multi_turn_position
);

  localparam int LOW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

  // a stalled word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mech_angle) && $stable(revolutions))
    else $error("stalled output word changed");

  // one word in flight: no second accept right after the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a fresh result follows its accepted input through the capture, multiply, angle and finish steps
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result without matching input");

  // low bits of the multi-turn position are the mechanical angle
  a_multi_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> multi_turn_position[LOW-1:0] == mech_angle[LOW-1:0])
    else $error("multi-turn position disagrees with angle");

endmodule

bind encoder_angle_processor_unit eap_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_eap_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .mech_angle          (mech_angle),
  .revolutions         (revolutions),
  .multi_turn_position (multi_turn_position)
);

>>> tb/testbench.sv
// testbench for encoder_angle_processor_unit: feeds raw encoder counts and checks
// every angle word against an in-bench angle and revolution tracker
// depends on eap_pkg and the rtl top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // addresses past the register file, writes there must change nothing
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int TURN = 65536;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int REV_LOOPS = 8;

  typedef struct packed {
    logic [15:0] mech;
    logic [15:0] single;
    logic [15:0] elec;
    logic [15:0] revs;
    logic [31:0] multi;
  } angle_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [eap_pkg::ADDR_W-1:0] paddr = '0;
  logic [eap_pkg::DATA_W-1:0] pwdata = '0;
  logic [eap_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] raw_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] mech_angle;
  logic [15:0] single_turn_angle;
  logic [15:0] elec_angle;
  logic signed [15:0] revolutions;
  logic signed [31:0] multi_turn_position;

  eap_pkg::cfg_t shadow = '{count_top: eap_pkg::RST_COUNT_TOP,
                            count_scale: eap_pkg::RST_COUNT_SCALE,
                            reverse_direction: eap_pkg::RST_REVERSE,
                            pole_pairs: eap_pkg::RST_POLE_PAIRS,
                            mech_offset: eap_pkg::RST_MECH_OFFSET,
                            elec_offset: eap_pkg::RST_ELEC_OFFSET};
  logic [15:0] last_angle = '0;
  logic [15:0] rev_count = '0;

  logic [15:0] count_backlog[$];
  angle_word_t angle_words_due[$];
  angle_word_t mon_want;
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_hold = 0;
  bit calm = 1'b0;
  bit no_idle = 1'b0;

  encoder_angle_processor_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .raw_count(raw_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .mech_angle(mech_angle), .single_turn_angle(single_turn_angle),
    .elec_angle(elec_angle), .revolutions(revolutions),
    .multi_turn_position(multi_turn_position)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // angle, offsets and revolution tracking for one raw count
  function automatic angle_word_t track_encoder(input logic [15:0] raw);
    logic [63:0] span;
    logic [63:0] prod;
    logic [15:0] ang;
    int diff;
    angle_word_t w;
    // mirrored count above top goes negative and wraps in 64 bits
    span = shadow.reverse_direction ? 64'(shadow.count_top) - 64'(raw) : 64'(raw);
    prod = span * 64'(shadow.count_scale);
    ang = prod[31:16];
    diff = int'(ang) - int'(last_angle);
    if (diff * 5 > 4 * TURN) rev_count = rev_count - 16'd1;
    else if (diff * 5 < -4 * TURN) rev_count = rev_count + 16'd1;
    last_angle = ang;
    w.mech = ang;
    w.single = ang + shadow.mech_offset;
    w.elec = 16'(32'(ang) * 32'(shadow.pole_pairs) - 32'(shadow.elec_offset));
    w.revs = rev_count;
    w.multi = {rev_count, ang};
    return w;
  endfunction

  // wait per word, with runs of back-to-back traffic
  function automatic int draw_wait();
    if ($urandom_range(0, 63) == 0) calm = !calm;
    if (no_idle || calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      eap_pkg::REG_COUNT_TOP:   shadow.count_top = val[15:0];
      eap_pkg::REG_COUNT_SCALE: shadow.count_scale = val;
      eap_pkg::REG_REVERSE:     shadow.reverse_direction = val[0];
      eap_pkg::REG_POLE_PAIRS:  shadow.pole_pairs = val[5:0];
      eap_pkg::REG_MECH_OFFSET: shadow.mech_offset = val[15:0];
      eap_pkg::REG_ELEC_OFFSET: shadow.elec_offset = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (count_backlog.size() != 0 || in_valid || angle_words_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_config();
    logic [15:0] top;
    logic [31:0] scale;
    logic [5:0] poles;
    case ($urandom_range(0, 5))
      0: top = 16'h0000;
      1: top = 16'hFFFF;
      2, 3: top = 16'($urandom_range(99, 8191));
      default: top = 16'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0: scale = 32'h0000_0000;
      1: scale = 32'hFFFF_FFFF;
      2: scale = $urandom();
      default: scale = 32'((64'd1 << 32) / (64'(top) + 64'd1));
    endcase
    case ($urandom_range(0, 5))
      0: poles = 6'd0;
      1: poles = 6'd63;
      default: poles = 6'($urandom_range(1, 63));
    endcase
    // upper bits beyond each register are junk and must be dropped
    write_reg(eap_pkg::REG_COUNT_TOP, {16'($urandom()), top});
    write_reg(eap_pkg::REG_COUNT_SCALE, scale);
    write_reg(eap_pkg::REG_REVERSE, {31'($urandom()), 1'($urandom())});
    write_reg(eap_pkg::REG_POLE_PAIRS, {26'($urandom()), poles});
    write_reg(eap_pkg::REG_MECH_OFFSET, {16'($urandom()), pick16()});
    write_reg(eap_pkg::REG_ELEC_OFFSET, {16'($urandom()), pick16()});
  endtask

  // mostly a shaft turning back and forth through the count range
  task automatic queue_random_phase(input int n);
    int m;
    int pos;
    int step;
    int span;
    int dir;
    int sel;
    m = int'(shadow.count_top) + 1;
    pos = int'($urandom_range(0, m - 1));
    span = m / 8 + 1;
    dir = 1;
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(0, 9));
      if (sel < 7) begin
        if ($urandom_range(0, 15) == 0) dir = -dir;
        step = dir * int'($urandom_range(0, span));
        pos = ((pos + step) % m + m) % m;
        count_backlog.push_back(16'(pos));
      end else if (sel < 9) begin
        count_backlog.push_back(16'($urandom()));
      end else begin
        count_backlog.push_back(16'(int'(shadow.count_top) + int'($urandom_range(1, 64))));
      end
    end
  endtask

  // driver: one count per word, held until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        angle_words_due.push_back(track_encoder(raw_count));
        in_gap = draw_wait();
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (count_backlog.size() != 0) begin
          in_valid <= 1'b1;
          raw_count <= count_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (angle_words_due.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none, got mech_angle %0h",
                   $time, mech_angle);
        end else begin
          mon_want = angle_words_due.pop_front();
          check_field("mech_angle", 32'(mon_want.mech), 32'(mech_angle));
          check_field("single_turn_angle", 32'(mon_want.single), 32'(single_turn_angle));
          check_field("elec_angle", 32'(mon_want.elec), 32'(elec_angle));
          check_field("revolutions", 32'(mon_want.revs), 32'($unsigned(revolutions)));
          check_field("multi_turn_position", mon_want.multi,
                      32'($unsigned(multi_turn_position)));
        end
        out_hold = draw_wait();
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready <= (out_hold == 0);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: ends of the range, counts past top, a wrap each way
    count_backlog = '{16'd0, 16'd3999, 16'd4000, 16'hFFFF, 16'h8000, 16'h5555,
                      16'hAAAA, 16'd3990, 16'd10, 16'd3990, 16'd1};
    wait_idle();

    // reversed, zero pole pairs, full mechanical and zero electrical offset; mirrored counts above top go negative
    write_reg(eap_pkg::REG_REVERSE, 32'd1);
    write_reg(eap_pkg::REG_POLE_PAIRS, 32'd0);
    write_reg(eap_pkg::REG_MECH_OFFSET, 32'h0000_FFFF);
    write_reg(eap_pkg::REG_ELEC_OFFSET, 32'd0);
    count_backlog = '{16'd0, 16'd3999, 16'd4000, 16'hFFFF};
    wait_idle();

    write_reg(eap_pkg::REG_POLE_PAIRS, 32'd63);
    write_reg(eap_pkg::REG_ELEC_OFFSET, 32'h0000_FFFF);
    write_reg(eap_pkg::REG_COUNT_TOP, 32'h0000_FFFF);
    write_reg(eap_pkg::REG_COUNT_SCALE, 32'hFFFF_FFFF);
    write_reg(eap_pkg::REG_REVERSE, 32'd0);
    count_backlog = '{16'd0, 16'd1, 16'hFFFF, 16'h8000};
    wait_idle();

    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h1234_5678);
    write_reg(eap_pkg::REG_COUNT_TOP, 32'd0);
    write_reg(eap_pkg::REG_REVERSE, 32'd1);
    write_reg(eap_pkg::REG_COUNT_SCALE, 32'd0);
    count_backlog = '{16'd0, 16'hFFFF};
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      random_config();
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    // unit scale makes angle equal the count; full-turn jumps one way, then the other
    write_reg(eap_pkg::REG_COUNT_SCALE, 32'h0001_0000);
    write_reg(eap_pkg::REG_REVERSE, 32'd0);
    no_idle = 1'b1;
    for (int i = 0; i < REV_LOOPS; i++) begin
      count_backlog.push_back(16'd60000);
      count_backlog.push_back(16'd1000);
      count_backlog.push_back(16'd30000);
    end
    for (int i = 0; i < REV_LOOPS; i++) begin
      count_backlog.push_back(16'd1000);
      count_backlog.push_back(16'd60000);
      count_backlog.push_back(16'd30000);
    end
    wait_idle();
    no_idle = 1'b0;

    queue_random_phase(20);
    wait_idle();

    if (errors == 0 && angle_words_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> encoder_angle_processor_unit.f
rtl/eap_pkg.sv
rtl/eap_regs.sv
rtl/eap_ctrl.sv
rtl/eap_datapath.sv
rtl/encoder_angle_processor_unit.sv
rtl/eap_checker.sv
tb/testbench.sv
